@@ rtl/core/itrd_pkg.sv @@
`default_nettype none

package itrd_pkg;

    localparam int CHAR_W    = 8;
    localparam int DIGIT_W   = 4;
    localparam int RADIX_W   = 5;
    localparam int ALPHA_W   = 64;
    localparam int REG_IDX_W = 2;
    localparam int DIV_STEPS = 8;

    typedef logic [RADIX_W-1:0]   radix_t;
    typedef logic [CHAR_W-1:0]    char_t;
    typedef logic [DIGIT_W-1:0]   digit_t;
    typedef logic [ALPHA_W-1:0]   alpha_t;
    typedef logic [REG_IDX_W-1:0] reg_idx_t;

    localparam radix_t MIN_RADIX = radix_t'(2);
    localparam radix_t MAX_RADIX = radix_t'(16);

    localparam char_t MINUS_CHAR = 8'h2D;

    localparam reg_idx_t REG_ALPHA_LOW  = 2'd0;
    localparam reg_idx_t REG_ALPHA_HIGH = 2'd1;
    localparam reg_idx_t REG_BASE_SIZE  = 2'd2;

    // Digit d maps to byte d of the 128-bit alphabet (low word holds 0..7).
    function automatic char_t digit_char(alpha_t lo, alpha_t hi, digit_t d);
        alpha_t word;
        word = d[DIGIT_W-1] ? hi : lo;
        return word[{d[DIGIT_W-2:0], 3'b000} +: CHAR_W];
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/itrd_front.sv @@
`default_nettype none

module itrd_front #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [VALUE_BITS-1:0] value,
    output logic                       busy,
    input  wire logic                  q_full,
    output logic                       push,
    output logic [VALUE_BITS:0]        push_data
);

    logic                  valid_reg, valid_next;
    logic                  neg_reg, neg_next;
    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic                  accept;

    assign push      = valid_reg && !q_full;
    assign busy      = valid_reg && q_full;
    assign accept    = start && !busy;
    assign push_data = {neg_reg, mag_reg};

    // Two's complement negate: the most negative value maps onto 2^(VALUE_BITS-1).
    always_comb
    begin
        valid_next = valid_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        if (accept)
        begin
            valid_next = 1'b1;
            neg_next   = value[VALUE_BITS-1];
            mag_next   = value[VALUE_BITS-1] ? (~value + VALUE_BITS'(1)) : value;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        mag_reg <= mag_next;
    end

endmodule

`default_nettype wire

@@ rtl/core/itrd_queue.sv @@
`default_nettype none

module itrd_queue #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      head_data,
    output logic                  full,
    output logic                  empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign head_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/itrd_back.sv @@
`default_nettype none

module itrd_back #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [VALUE_BITS:0]   head_data,
    input  wire logic                  q_empty,
    output logic                       pop,
    input  wire itrd_pkg::radix_t      radix,
    input  wire itrd_pkg::alpha_t      alpha_low,
    input  wire itrd_pkg::alpha_t      alpha_high,
    output itrd_pkg::char_t            character,
    output logic                       last,
    output logic                       strobe
);

    import itrd_pkg::*;

    localparam int CYC   = (VALUE_BITS + DIV_STEPS - 1) / DIV_STEPS;
    localparam int DW    = CYC * DIV_STEPS;
    localparam int CYC_W = (CYC > 1) ? $clog2(CYC) : 1;
    localparam int IDX_W = $clog2(VALUE_BITS);
    localparam int CNT_W = $clog2(VALUE_BITS + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DIV    = 2'd1;
    localparam logic [1:0] ST_SIGN   = 2'd2;
    localparam logic [1:0] ST_DIGITS = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic             neg_reg, neg_next;
    logic [DW-1:0]    dvd_reg, dvd_next;
    logic [DW-1:0]    quo_reg, quo_next;
    radix_t           rem_reg, rem_next;
    logic [CYC_W-1:0] cyc_reg, cyc_next;
    logic [CNT_W-1:0] nd_reg, nd_next;
    logic [IDX_W-1:0] emit_reg, emit_next;
    logic             strobe_reg, strobe_next;
    char_t            char_reg, char_next;
    logic             last_reg, last_next;

    digit_t           digit_reg [VALUE_BITS];
    logic             digit_we;

    radix_t           div_rem;
    logic [DW-1:0]    div_dvd;
    logic [DW-1:0]    div_quo;
    digit_t           emit_digit;

    assign character  = char_reg;
    assign last       = last_reg;
    assign strobe     = strobe_reg;
    assign pop        = (state_reg == ST_IDLE) && !q_empty;
    assign emit_digit = digit_reg[emit_reg];

    // Restoring long division by the radix, DIV_STEPS dividend bits per cycle.
    // Remainder stays below the radix, so it fits in DIGIT_W bits before each shift.
    always_comb
    begin
        div_rem = rem_reg;
        div_dvd = dvd_reg;
        div_quo = quo_reg;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            div_rem = {div_rem[DIGIT_W-1:0], div_dvd[DW-1]};
            div_dvd = {div_dvd[DW-2:0], 1'b0};
            if (div_rem >= radix)
            begin
                div_rem = div_rem - radix;
                div_quo = {div_quo[DW-2:0], 1'b1};
            end
            else
            begin
                div_quo = {div_quo[DW-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        neg_next    = neg_reg;
        dvd_next    = dvd_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        cyc_next    = cyc_reg;
        nd_next     = nd_reg;
        emit_next   = emit_reg;
        strobe_next = 1'b0;
        char_next   = char_reg;
        last_next   = last_reg;
        digit_we    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    neg_next   = head_data[VALUE_BITS];
                    dvd_next   = DW'(head_data[VALUE_BITS-1:0]);
                    quo_next   = '0;
                    rem_next   = '0;
                    cyc_next   = '0;
                    nd_next    = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                dvd_next = div_dvd;
                quo_next = div_quo;
                rem_next = div_rem;
                cyc_next = cyc_reg + CYC_W'(1);
                if (cyc_reg == CYC_W'(CYC - 1))
                begin
                    digit_we = 1'b1;
                    nd_next  = nd_reg + CNT_W'(1);
                    if (div_quo == '0 || nd_reg == CNT_W'(VALUE_BITS - 1))
                    begin
                        emit_next  = nd_reg[IDX_W-1:0];
                        state_next = neg_reg ? ST_SIGN : ST_DIGITS;
                    end
                    else
                    begin
                        dvd_next = div_quo;
                        rem_next = '0;
                        cyc_next = '0;
                    end
                end
            end
            ST_SIGN:
            begin
                strobe_next = 1'b1;
                char_next   = MINUS_CHAR;
                last_next   = 1'b0;
                state_next  = ST_DIGITS;
            end
            ST_DIGITS:
            begin
                strobe_next = 1'b1;
                char_next   = digit_char(alpha_low, alpha_high, emit_digit);
                last_next   = (emit_reg == '0);
                if (emit_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    emit_next = emit_reg - IDX_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        dvd_reg  <= dvd_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        cyc_reg  <= cyc_next;
        nd_reg   <= nd_next;
        emit_reg <= emit_next;
        char_reg <= char_next;
        last_reg <= last_next;
        if (digit_we)
        begin
            digit_reg[nd_reg[IDX_W-1:0]] <= div_rem[DIGIT_W-1:0];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/integer_to_radix_digits_unit.sv @@
`default_nettype none

// Signed integer to radix text, one character per strobe.
// Each digit takes one pass of the 8-bit-per-cycle divider. Then one character per cycle
// (sign, then digits). The converter takes a new item only after its last character;
// a 2-entry queue buffers inputs.
// Reset clears control state; alphabet resets to zero, base size to 2.

module integer_to_radix_digits_unit #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [VALUE_BITS-1:0]     value,
    output itrd_pkg::char_t                character,
    output logic                           last,
    output logic                           strobe,
    input  wire logic                      wr_en,
    input  wire itrd_pkg::reg_idx_t        wr_index,
    input  wire itrd_pkg::alpha_t          wr_data
);

    import itrd_pkg::*;

    alpha_t  alpha_low_reg;
    alpha_t  alpha_high_reg;
    radix_t  base_reg;
    radix_t  radix;

    logic                q_full;
    logic                q_empty;
    logic                q_push;
    logic                q_pop;
    logic [VALUE_BITS:0] q_push_data;
    logic [VALUE_BITS:0] q_head_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_low_reg  <= '0;
            alpha_high_reg <= '0;
            base_reg       <= MIN_RADIX;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_ALPHA_LOW:  alpha_low_reg  <= wr_data;
                REG_ALPHA_HIGH: alpha_high_reg <= wr_data;
                REG_BASE_SIZE:  base_reg       <= wr_data[RADIX_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        priority if (base_reg < MIN_RADIX)
        begin
            radix = MIN_RADIX;
        end
        else if (base_reg > MAX_RADIX)
        begin
            radix = MAX_RADIX;
        end
        else
        begin
            radix = base_reg;
        end
    end

    itrd_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .value     (value),
        .busy      (busy),
        .q_full    (q_full),
        .push      (q_push),
        .push_data (q_push_data)
    );

    itrd_queue #(
        .WIDTH (VALUE_BITS + 1),
        .DEPTH (2)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .head_data (q_head_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    itrd_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_data  (q_head_data),
        .q_empty    (q_empty),
        .pop        (q_pop),
        .radix      (radix),
        .alpha_low  (alpha_low_reg),
        .alpha_high (alpha_high_reg),
        .character  (character),
        .last       (last),
        .strobe     (strobe)
    );

endmodule

`default_nettype wire

@@ tb/integer_to_radix_digits_unit_tb.sv @@
`timescale 1ns / 1ps

module integer_to_radix_digits_unit_tb;

    import itrd_pkg::*;

    localparam int       VAL_W       = 32;
    localparam int       DIR_ROWS    = 35;
    localparam int       PHASES      = 8;
    localparam int       PHASE_ITEMS = 50;
    localparam int       SETTLE      = 8;
    localparam int       TAIL        = 40;
    localparam int       CYCLE_LIMIT = 500000;
    localparam reg_idx_t REG_SPARE   = reg_idx_t'(3);

    typedef enum logic { ROW_WRITE, ROW_CONVERT } row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        reg_idx_t         idx;
        alpha_t           data;
        logic [VAL_W-1:0] val;
    } dir_row_t;

    typedef struct packed {
        char_t ch;
        logic  fin;
    } text_char_t;

    // Directed table; text column holds a hand-written expectation, empty means predicted.
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{ROW_CONVERT, REG_ALPHA_LOW,  64'h0,                  32'h0000_0000},
        '{ROW_CONVERT, REG_ALPHA_LOW,  64'h0,                  32'hFFFF_FFFF},
        '{ROW_WRITE,   REG_ALPHA_LOW,  64'h3736_3534_3332_3130, 32'h0},
        '{ROW_WRITE,   REG_ALPHA_HIGH, 64'h4645_4443_4241_3938, 32'h0},
        '{ROW_CONVERT, REG_ALPHA_LOW,  64'h0,                  32'h0000_0000},
        '{ROW_CONVERT, REG_ALPHA_LOW,  64'h0,                  32'h8000_0000},
        '{ROW_CONVERT, REG_ALPHA_LOW,  64'h0,                  32'h7FFF_FFFF},
        '{ROW_WRITE,   REG_BASE_SIZE,  64'd16,                 32'h0},
        '{ROW_CONVERT, REG_ALPHA_LOW,  64'h0,                  32'h7FFF_FFFF},
        '{ROW_CONVERT, REG_ALPHA_LOW,  64'h0,                  32'h8000_0000},
        '{ROW_CONVERT, REG_ALPHA_LOW,  64'h0,                  32'hFFFF_FFFF},
        '{ROW_CONVERT, REG_ALPHA_LOW,  64'h0,                  32'hDEAD_BEEF},
        '{ROW_WRITE,   REG_BASE_SIZE,  64'd10,                 32'h0},
        '{ROW_CONVERT, REG_ALPHA_LOW,  64'h0,                  32'h7FFF_FFFF},
        '{ROW_CONVERT, REG_ALPHA_LOW,  64'h0,                  32'h8000_0000},
        '{ROW_CONVERT, REG_ALPHA_LOW,  64'h0,                  32'h0000_0000},
        '{ROW_WRITE,   REG_BASE_SIZE,  64'd1,                  32'h0},
        '{ROW_CONVERT, REG_ALPHA_LOW,  64'h0,                  32'd5},
        '{ROW_WRITE,   REG_BASE_SIZE,  64'hFFFF_FFFF_FFFF_FFFF, 32'h0},
        '{ROW_CONVERT, REG_ALPHA_LOW,  64'h0,                  32'd255},
        '{ROW_WRITE,   REG_BASE_SIZE,  64'd17,                 32'h0},
        '{ROW_CONVERT, REG_ALPHA_LOW,  64'h0,                  32'h1234_ABCD},
        '{ROW_WRITE,   REG_SPARE,      64'h0123_4567_89AB_CDEF, 32'h0},
        '{ROW_CONVERT, REG_ALPHA_LOW,  64'h0,                  32'd100},
        '{ROW_WRITE,   REG_BASE_SIZE,  64'd0,                  32'h0},
        '{ROW_CONVERT, REG_ALPHA_LOW,  64'h0,                  32'hFFFF_FFF9},
        '{ROW_WRITE,   REG_BASE_SIZE,  64'd3,                  32'h0},
        '{ROW_CONVERT, REG_ALPHA_LOW,  64'h0,                  32'h8000_0000},
        '{ROW_CONVERT, REG_ALPHA_LOW,  64'h0,                  32'h7FFF_FFFF},
        '{ROW_WRITE,   REG_ALPHA_LOW,  64'h0000_4141_0000_4141, 32'h0},
        '{ROW_CONVERT, REG_ALPHA_LOW,  64'h0,                  32'h1234_5678},
        '{ROW_WRITE,   REG_BASE_SIZE,  64'd7,                  32'h0},
        '{ROW_CONVERT, REG_ALPHA_LOW,  64'h0,                  32'd1234567},
        '{ROW_WRITE,   REG_BASE_SIZE,  64'd36,                 32'h0},
        '{ROW_CONVERT, REG_ALPHA_LOW,  64'h0,                  32'hFFFF_0000}
    };

    string dir_text [DIR_ROWS] = '{
        "", "", "", "", "0",
        {"-1", "0000000000", "0000000000", "0000000000", "0"},
        "", "", "7FFFFFFF", "-80000000", "-1", "", "",
        "2147483647", "-2147483648", "0", "", "101", "", "FF", "", "",
        "", "64", "", "-111", "", "", "", "", "", "", "", "", ""
    };

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic [VAL_W-1:0] value;
    char_t            character;
    logic             last;
    logic             strobe;
    logic             wr_en;
    reg_idx_t         wr_index;
    alpha_t           wr_data;

    // tb copy of the register file
    alpha_t     alpha_lo;
    alpha_t     alpha_hi;
    radix_t     base_reg;

    text_char_t pending_chars [$];
    int         errors;
    int         cycle_count;

    integer_to_radix_digits_unit #(
        .VALUE_BITS(VAL_W)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .value    (value),
        .character(character),
        .last     (last),
        .strobe   (strobe),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always #2 clk = ~clk;

    function automatic logic [31:0] radix_now();
        logic [31:0] r;
        r = {27'b0, base_reg};
        if (r < 2)
            r = 2;
        if (r > 16)
            r = 16;
        return r;
    endfunction

    function automatic char_t alphabet_char(input logic [3:0] d);
        char_t c;
        if (d < 8)
            c = alpha_lo[d[2:0]*8 +: 8];
        else
            c = alpha_hi[d[2:0]*8 +: 8];
        return c;
    endfunction

    // Sign first, then digits most significant first; last on the final one.
    function automatic void predict_text(input logic [VAL_W-1:0] v);
        logic        neg;
        logic [31:0] mag;
        logic [31:0] rdx;
        logic [3:0]  dg [VAL_W];
        int          nd;
        neg = v[VAL_W-1];
        mag = neg ? (~v + 1'b1) : v;
        rdx = radix_now();
        nd  = 0;
        do begin
            dg[nd] = 4'((mag % rdx));
            mag    = mag / rdx;
            nd++;
        end while (mag != 0 && nd < VAL_W);
        if (neg)
            pending_chars.push_back('{ch: MINUS_CHAR, fin: 1'b0});
        for (int k = nd - 1; k >= 0; k--)
            pending_chars.push_back('{ch: alphabet_char(dg[k]), fin: (k == 0)});
    endfunction

    function automatic void expect_text(input string t);
        for (int i = 0; i < t.len(); i++)
            pending_chars.push_back('{ch: char_t'(t[i]), fin: (i == t.len() - 1)});
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        logic [VAL_W-1:0] v;
        logic [31:0]      rdx;
        longint           p;
        rdx = radix_now();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            4: begin
                case ($urandom_range(0, 4))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7FFF_FFFF;
                    2:       v = 32'h0000_0000;
                    3:       v = 32'hFFFF_FFFF;
                    default: v = 32'h0000_0001;
                endcase
            end
            5: begin
                v = $urandom_range(0, rdx * rdx);
                if ($urandom_range(0, 1) == 1)
                    v = -v;
            end
            6: begin
                // neighbors of a power of the radix, where the digit count changes
                p = 1;
                repeat ($urandom_range(1, 31))
                    if (p * rdx <= 64'h7FFF_FFFF)
                        p = p * rdx;
                v = p[31:0] + $urandom_range(0, 2) - 1;
                if ($urandom_range(0, 1) == 1)
                    v = -v;
            end
            default: begin
                v = $urandom >> $urandom_range(0, 31);
                if ($urandom_range(0, 1) == 1)
                    v = -v;
            end
        endcase
        return v;
    endfunction

    task automatic send_value(input logic [VAL_W-1:0] v, input int gap, input string t);
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (t.len() == 0)
            predict_text(v);
        else
            expect_text(t);
    endtask

    // Ends at a falling edge with the block drained.
    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        while (pending_chars.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // Called at a falling edge; returns at a falling edge with wr_en low.
    task automatic write_reg(input reg_idx_t idx, input alpha_t data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        case (idx)
            REG_ALPHA_LOW:  alpha_lo = data;
            REG_ALPHA_HIGH: alpha_hi = data;
            REG_BASE_SIZE:  base_reg = data[RADIX_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        wr_en <= 1'b0;
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && strobe === 1'b1)
        begin
            if (pending_chars.size() == 0)
            begin
                $error("character %h with no transfer pending", character);
                errors++;
            end
            else
            begin
                text_char_t exp_c;
                exp_c = pending_chars.pop_front();
                if (character !== exp_c.ch)
                begin
                    $error("character: expected %h, got %h", exp_c.ch, character);
                    errors++;
                end
                if (last !== exp_c.fin)
                begin
                    $error("last: expected %b, got %b", exp_c.fin, last);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        alpha_t base_data;
        int     gap;
        clk         = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        value       = '0;
        wr_en       = 1'b0;
        wr_index    = REG_ALPHA_LOW;
        wr_data     = '0;
        alpha_lo    = '0;
        alpha_hi    = '0;
        base_reg    = MIN_RADIX;
        errors      = 0;
        cycle_count = 0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            if (DIR_TABLE[r].kind == ROW_WRITE)
            begin
                wait_idle();
                write_reg(DIR_TABLE[r].idx, DIR_TABLE[r].data);
            end
            else
                send_value(DIR_TABLE[r].val, $urandom_range(0, 14), dir_text[r]);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_idle();
            if (ph % 3 == 0)
            begin
                write_reg(REG_ALPHA_LOW,  64'h3736_3534_3332_3130);
                write_reg(REG_ALPHA_HIGH, 64'h4645_4443_4241_3938);
            end
            else
            begin
                write_reg(REG_ALPHA_LOW,  {$urandom, $urandom});
                write_reg(REG_ALPHA_HIGH, {$urandom, $urandom});
            end
            base_data = {$urandom, $urandom};
            if (ph == 0)
                base_data[RADIX_W-1:0] = MIN_RADIX;
            else if (ph == 1)
                base_data[RADIX_W-1:0] = MAX_RADIX;
            else if ($urandom_range(0, 3) == 0)
                base_data[RADIX_W-1:0] = radix_t'($urandom_range(0, 31));
            else
                base_data[RADIX_W-1:0] = radix_t'($urandom_range(2, 16));
            write_reg(REG_BASE_SIZE, base_data);

            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // let the block drain completely now and then
                if ($urandom_range(0, 39) == 0)
                    wait_idle();
                gap = (ph % 4 == 2) ? 0 : $urandom_range(0, 14);
                send_value(pick_value(), gap, "");
            end
        end

        wait_idle();
        repeat (TAIL) @(negedge clk);
        if (errors == 0 && pending_chars.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/itrd_pkg.sv
rtl/core/itrd_front.sv
rtl/core/itrd_queue.sv
rtl/core/itrd_back.sv
rtl/core/integer_to_radix_digits_unit.sv
tb/integer_to_radix_digits_unit_tb.sv
